/* hdl/midpoint_ellipse_rasterizer_assert.svh */
// Assertion macros used by the port-level checker file.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MER_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define MER_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hdl/mer_pkg.sv */
// Types, widths and command codes for the midpoint ellipse rasterizer.
`default_nettype none
package mer_pkg;

   localparam int COORD_BITS = 10;
   localparam int OUT_BITS   = 12;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int TMP_BITS   = 2 * (COORD_BITS + 1);
   localparam int MUL_BITS   = SQ_BITS + TMP_BITS;
   localparam int STEP_BITS  = 3 * COORD_BITS + 2;
   localparam int DEC_BITS   = 48;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] x_center;
      logic [COORD_BITS-1:0] y_center;
      logic [COORD_BITS-1:0] radius_x;
      logic [COORD_BITS-1:0] radius_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] px_right;
      logic signed [OUT_BITS-1:0] px_left;
      logic signed [OUT_BITS-1:0] py_lower;
      logic signed [OUT_BITS-1:0] py_upper;
      logic                       last;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ_RX,
      OP_SQ_RY,
      OP_RXSQ_RY,
      OP_START_DEC,
      OP_SW_TX,
      OP_SW_TY,
      OP_SW_P3,
      OP_SW_P4,
      OP_SW_P5,
      OP_SW_DEC,
      OP_R1_A,
      OP_R1_B,
      OP_R2_A,
      OP_R2_B
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic region_two;
      logic dx_lt_dy;
   } status_type;

endpackage
`default_nettype wire

/* hdl/midpoint_ellipse_rasterizer.sv */
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-------------------------------------
//   req     | req_valid, req_ready, req_data | start (center, radii) or step command
//   rsp     | rsp_valid, rsp_ready, rsp_data | four reflected pixel coordinates, last
//
// Start: the accept loads the geometry, then three passes through the shared multiplier and the decision set-up.
// Step in region 1 or region 2: offset/step update, then decision update.
// Step that crosses into region 2: five multiplies on the shared multiplier, then the region-2 step.
// Step while no ellipse is active: accepted, no result.
// Reset is synchronous; the block comes out idle. A stalled result holds the block in
// its output wait and no new req beat is taken until the result register is loaded.
`default_nettype none
module midpoint_ellipse_rasterizer (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  mer_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output mer_pkg::rsp_type rsp_data
);
   import mer_pkg::*;

   cmd_type    cmd;
   status_type status;

   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_data.mode),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   mer_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

/* hdl/mer_datapath.sv */
// Datapath: latched geometry, shared multiplier, decision update and output register.
`default_nettype none
module mer_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  mer_pkg::req_type    req_data,
   input  mer_pkg::cmd_type    cmd,
   output mer_pkg::status_type status,
   output mer_pkg::rsp_type    rsp_data
);
   import mer_pkg::*;

   logic [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_BITS-1:0] rad_x_ff, rad_x_in, rad_y_ff, rad_y_in;
   logic [COORD_BITS-1:0] off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic [SQ_BITS-1:0]    rx_sq_ff, rx_sq_in, ry_sq_ff, ry_sq_in;
   logic [STEP_BITS-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [DEC_BITS-1:0]   dec_ff, dec_in;
   logic [TMP_BITS-1:0]   tmp_ff, tmp_in;
   logic [MUL_BITS-1:0]   prod_ff, prod_in;
   logic                  region_two_ff, region_two_in;
   logic                  busy_ff, busy_in;
   logic                  branch_ff, branch_in;
   rsp_type               rsp_ff, rsp_in;

   logic [SQ_BITS-1:0]    mul_a;
   logic [TMP_BITS-1:0]   mul_b;
   logic [COORD_BITS:0]   tx;
   logic [COORD_BITS-1:0] ty;
   logic [DEC_BITS-1:0]   dx_w, dy_w, rx_w, ry_w, term;
   logic                  dec_neg, dec_pos;

   always_comb begin
      tx      = {off_x_ff, 1'b1};
      ty      = off_y_ff - COORD_BITS'(1);
      dx_w    = DEC_BITS'(dx_ff);
      dy_w    = DEC_BITS'(dy_ff);
      rx_w    = DEC_BITS'(rx_sq_ff);
      ry_w    = DEC_BITS'(ry_sq_ff);
      dec_neg = dec_ff[DEC_BITS-1];
      dec_pos = !dec_neg && (dec_ff != '0);

      cx_in         = cx_ff;
      cy_in         = cy_ff;
      rad_x_in      = rad_x_ff;
      rad_y_in      = rad_y_ff;
      off_x_in      = off_x_ff;
      off_y_in      = off_y_ff;
      rx_sq_in      = rx_sq_ff;
      ry_sq_in      = ry_sq_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dec_in        = dec_ff;
      tmp_in        = tmp_ff;
      region_two_in = region_two_ff;
      busy_in       = busy_ff;
      branch_in     = branch_ff;
      rsp_in        = rsp_ff;
      mul_a         = '0;
      mul_b         = '0;
      term          = '0;

      unique case (cmd.op)
         OP_LOAD: begin
            cx_in         = req_data.x_center;
            cy_in         = req_data.y_center;
            rad_x_in      = req_data.radius_x;
            rad_y_in      = req_data.radius_y;
            off_x_in      = '0;
            off_y_in      = req_data.radius_y;
            dx_in         = '0;
            region_two_in = 1'b0;
         end
         OP_SQ_RX: begin
            mul_a = SQ_BITS'(rad_x_ff);
            mul_b = TMP_BITS'(rad_x_ff);
         end
         OP_SQ_RY: begin
            rx_sq_in = prod_ff[SQ_BITS-1:0];
            mul_a    = SQ_BITS'(rad_y_ff);
            mul_b    = TMP_BITS'(rad_y_ff);
         end
         OP_RXSQ_RY: begin
            ry_sq_in = prod_ff[SQ_BITS-1:0];
            mul_a    = rx_sq_ff;
            mul_b    = TMP_BITS'(rad_y_ff);
         end
         OP_START_DEC: begin
            dy_in  = STEP_BITS'({prod_ff, 1'b0});
            dec_in = DEC_BITS'({ry_sq_ff, 2'b00}) - DEC_BITS'({prod_ff, 2'b00}) + rx_w;
         end
         OP_SW_TX: begin
            mul_a = SQ_BITS'(tx);
            mul_b = TMP_BITS'(tx);
         end
         OP_SW_TY: begin
            tmp_in = prod_ff[TMP_BITS-1:0];
            mul_a  = SQ_BITS'(ty);
            mul_b  = TMP_BITS'(ty);
         end
         OP_SW_P3: begin
            tmp_in = prod_ff[TMP_BITS-1:0];
            mul_a  = ry_sq_ff;
            mul_b  = tmp_ff;
         end
         OP_SW_P4: begin
            dec_in = DEC_BITS'(prod_ff);
            mul_a  = rx_sq_ff;
            mul_b  = tmp_ff;
         end
         OP_SW_P5: begin
            dec_in = dec_ff + DEC_BITS'({prod_ff, 2'b00});
            mul_a  = rx_sq_ff;
            mul_b  = TMP_BITS'(ry_sq_ff);
         end
         OP_SW_DEC: begin
            dec_in        = dec_ff - DEC_BITS'({prod_ff, 2'b00});
            region_two_in = 1'b1;
         end
         OP_R1_A: begin
            off_x_in  = off_x_ff + COORD_BITS'(1);
            dx_in     = dx_ff + STEP_BITS'({ry_sq_ff, 1'b0});
            branch_in = dec_neg;
            if (!dec_neg) begin
               off_y_in = off_y_ff - COORD_BITS'(1);
               dy_in    = dy_ff - STEP_BITS'({rx_sq_ff, 1'b0});
            end
         end
         OP_R1_B: begin
            term   = branch_ff ? (dx_w + ry_w) : (dx_w - dy_w + ry_w);
            dec_in = dec_ff + {term[DEC_BITS-3:0], 2'b00};
         end
         OP_R2_A: begin
            off_y_in  = off_y_ff - COORD_BITS'(1);
            dy_in     = dy_ff - STEP_BITS'({rx_sq_ff, 1'b0});
            branch_in = dec_pos;
            if (!dec_pos) begin
               off_x_in = off_x_ff + COORD_BITS'(1);
               dx_in    = dx_ff + STEP_BITS'({ry_sq_ff, 1'b0});
            end
         end
         OP_R2_B: begin
            term   = branch_ff ? (rx_w - dy_w) : (dx_w - dy_w + rx_w);
            dec_in = dec_ff + {term[DEC_BITS-3:0], 2'b00};
         end
         default: ;
      endcase

      prod_in = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);

      if (cmd.load_out) begin
         rsp_in.px_right = OUT_BITS'(cx_ff) + OUT_BITS'(off_x_ff);
         rsp_in.px_left  = OUT_BITS'(cx_ff) - OUT_BITS'(off_x_ff);
         rsp_in.py_lower = OUT_BITS'(cy_ff) + OUT_BITS'(off_y_ff);
         rsp_in.py_upper = OUT_BITS'(cy_ff) - OUT_BITS'(off_y_ff);
         rsp_in.last     = (off_y_ff == '0);
         busy_in         = (off_y_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rad_x_ff <= rad_x_in;
      rad_y_ff <= rad_y_in;
      off_x_ff <= off_x_in;
      off_y_ff <= off_y_in;
      rx_sq_ff <= rx_sq_in;
      ry_sq_ff <= ry_sq_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dec_ff   <= dec_in;
      tmp_ff   <= tmp_in;
      prod_ff  <= prod_in;
      branch_ff <= branch_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         region_two_ff <= 1'b0;
         busy_ff       <= 1'b0;
      end else begin
         region_two_ff <= region_two_in;
         busy_ff       <= busy_in;
      end
   end

   assign status.busy       = busy_ff;
   assign status.region_two = region_two_ff;
   assign status.dx_lt_dy   = (dx_ff < dy_ff);
   assign rsp_data          = rsp_ff;

endmodule
`default_nettype wire

/* hdl/mer_ctrl.sv */
// Controller: sequences start, step and region-switch operations and owns rsp valid.
`default_nettype none
module mer_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire                 req_mode,
   input  mer_pkg::status_type status,
   output mer_pkg::cmd_type    cmd,
   output logic                rsp_valid,
   input  wire                 rsp_ready
);
   import mer_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_RXSQ_RY,
      ST_START_DEC,
      ST_SW_TY,
      ST_SW_P3,
      ST_SW_P4,
      ST_SW_P5,
      ST_SW_DEC,
      ST_R2_A,
      ST_R1_B,
      ST_R2_B,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      req_fire;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      req_fire     = req_valid && (state_ff == ST_IDLE);
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.load_out = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_START) begin
                  cmd.op   = OP_LOAD;
                  state_in = ST_SQ_RX;
               end else if (status.busy) begin
                  if (status.region_two) begin
                     cmd.op   = OP_R2_A;
                     state_in = ST_R2_B;
                  end else if (status.dx_lt_dy) begin
                     cmd.op   = OP_R1_A;
                     state_in = ST_R1_B;
                  end else begin
                     cmd.op   = OP_SW_TX;
                     state_in = ST_SW_TY;
                  end
               end
            end
         end
         ST_SQ_RX: begin
            cmd.op   = OP_SQ_RX;
            state_in = ST_SQ_RY;
         end
         ST_SQ_RY: begin
            cmd.op   = OP_SQ_RY;
            state_in = ST_RXSQ_RY;
         end
         ST_RXSQ_RY: begin
            cmd.op   = OP_RXSQ_RY;
            state_in = ST_START_DEC;
         end
         ST_SW_TY: begin
            cmd.op   = OP_SW_TY;
            state_in = ST_SW_P3;
         end
         ST_SW_P3: begin
            cmd.op   = OP_SW_P3;
            state_in = ST_SW_P4;
         end
         ST_SW_P4: begin
            cmd.op   = OP_SW_P4;
            state_in = ST_SW_P5;
         end
         ST_SW_P5: begin
            cmd.op   = OP_SW_P5;
            state_in = ST_SW_DEC;
         end
         ST_SW_DEC: begin
            cmd.op   = OP_SW_DEC;
            state_in = ST_R2_A;
         end
         ST_R2_A: begin
            cmd.op   = OP_R2_A;
            state_in = ST_R2_B;
         end
         ST_START_DEC, ST_R1_B, ST_R2_B: begin
            if (state_ff == ST_START_DEC) begin
               cmd.op = OP_START_DEC;
            end else if (state_ff == ST_R1_B) begin
               cmd.op = OP_R1_B;
            end else begin
               cmd.op = OP_R2_B;
            end
            cmd.load_out = slot_free;
            state_in     = slot_free ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            cmd.load_out = slot_free;
            state_in     = slot_free ? ST_IDLE : ST_EMIT;
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* hdl/mer_checker.sv */
// Port-level checker for the midpoint ellipse rasterizer and its bind.
`default_nettype none
`include "midpoint_ellipse_rasterizer_assert.svh"
module mer_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input mer_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input mer_pkg::rsp_type rsp_data
);
   import mer_pkg::*;

   `MER_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MER_ASSERT_NEXT(rsp_stable_a, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   // a start beat occupies the multiplier, so req_ready is low after its accept
   `MER_ASSERT_NEXT(start_busy_a, clock, reset,
      req_valid && req_ready && (req_data.mode == MODE_START), !req_ready)
   // last marks exactly the beat whose vertical offset is zero
   `MER_ASSERT_IMPL(last_rows_a, clock, reset, rsp_valid,
      rsp_data.last == (rsp_data.py_lower == rsp_data.py_upper))

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_checker (.*);
`default_nettype wire

/* test/ellipse_tracker_pkg.sv */
// Point-set predictor and result checker for the midpoint ellipse rasterizer bench.
`timescale 1ns / 100ps
package ellipse_tracker_pkg;
   import mer_pkg::*;

   class ellipse_tracker;
      logic [COORD_BITS-1:0] off_x, off_y, cx, cy;
      logic [DEC_BITS-1:0]   decision;
      logic [SQ_BITS-1:0]    rx_sq, ry_sq;
      logic [STEP_BITS-1:0]  step_dx, step_dy;
      bit                    region_two, drawing;
      rsp_type               pending_points[$];
      int                    errors;

      function new();
         off_x = '0; off_y = '0; cx = '0; cy = '0;
         decision = '0; rx_sq = '0; ry_sq = '0;
         step_dx = '0; step_dy = '0;
         region_two = 1'b0; drawing = 1'b0;
         errors = 0;
      endfunction

      function bit is_drawing();
         return drawing;
      endfunction

      function int outstanding();
         return pending_points.size();
      endfunction

      // Advances the predicted walk by one accepted beat; returns 1 if a point set follows.
      function bit note_command(req_type item);
         logic [63:0] rx, ry, tx, ty;
         rsp_type pts;
         if (item.mode == MODE_START) begin
            rx = 64'(item.radius_x);
            ry = 64'(item.radius_y);
            cx = item.x_center;
            cy = item.y_center;
            rx_sq = SQ_BITS'(rx * rx);
            ry_sq = SQ_BITS'(ry * ry);
            off_x = '0;
            off_y = item.radius_y;
            step_dx = '0;
            step_dy = STEP_BITS'(64'd2 * rx * rx * ry);
            decision = DEC_BITS'(64'd4 * ry * ry - 64'd4 * rx * rx * ry + rx * rx);
            region_two = 1'b0;
            drawing = 1'b1;
         end else if (!drawing) begin
            return 1'b0;
         end else if (!region_two && step_dx < step_dy) begin
            off_x = off_x + COORD_BITS'(1);
            step_dx = step_dx + STEP_BITS'({ry_sq, 1'b0});
            if (decision[DEC_BITS-1]) begin
               decision = decision + ((DEC_BITS'(step_dx) + DEC_BITS'(ry_sq)) << 2);
            end else begin
               off_y = off_y - COORD_BITS'(1);
               step_dy = step_dy - STEP_BITS'({rx_sq, 1'b0});
               decision = decision + ((DEC_BITS'(step_dx) - DEC_BITS'(step_dy)
                                       + DEC_BITS'(ry_sq)) << 2);
            end
         end else begin
            if (!region_two) begin
               tx = (64'(off_x) << 1) + 64'd1;
               ty = 64'(off_y) - 64'd1;
               region_two = 1'b1;
               decision = DEC_BITS'(64'(ry_sq) * tx * tx + 64'd4 * 64'(rx_sq) * ty * ty
                                    - 64'd4 * 64'(rx_sq) * 64'(ry_sq));
            end
            off_y = off_y - COORD_BITS'(1);
            step_dy = step_dy - STEP_BITS'({rx_sq, 1'b0});
            if (!decision[DEC_BITS-1] && decision != '0) begin
               decision = decision + ((DEC_BITS'(rx_sq) - DEC_BITS'(step_dy)) << 2);
            end else begin
               off_x = off_x + COORD_BITS'(1);
               step_dx = step_dx + STEP_BITS'({ry_sq, 1'b0});
               decision = decision + ((DEC_BITS'(step_dx) - DEC_BITS'(step_dy)
                                       + DEC_BITS'(rx_sq)) << 2);
            end
         end
         pts.px_right = OUT_BITS'(cx) + OUT_BITS'(off_x);
         pts.px_left  = OUT_BITS'(cx) - OUT_BITS'(off_x);
         pts.py_lower = OUT_BITS'(cy) + OUT_BITS'(off_y);
         pts.py_upper = OUT_BITS'(cy) - OUT_BITS'(off_y);
         pts.last     = (off_y == '0);
         if (off_y == '0) drawing = 1'b0;
         pending_points.push_back(pts);
         return 1'b1;
      endfunction

      function void compare_field(string field, logic signed [OUT_BITS-1:0] want,
                                  logic signed [OUT_BITS-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_point_set(rsp_type got);
         rsp_type want;
         if (pending_points.size() == 0) begin
            $error("point set with none pending: right %0d left %0d lower %0d upper %0d last %0d",
                   got.px_right, got.px_left, got.py_lower, got.py_upper, got.last);
            errors++;
            return;
         end
         want = pending_points.pop_front();
         compare_field("px_right", want.px_right, got.px_right);
         compare_field("px_left", want.px_left, got.px_left);
         compare_field("py_lower", want.py_lower, got.py_lower);
         compare_field("py_upper", want.py_upper, got.py_upper);
         compare_field("last", OUT_BITS'(want.last), OUT_BITS'(got.last));
      endfunction
   endclass

endpackage

/* test/tb_top.sv */
// Top-level bench: drives start and step beats, stalls both channels, checks every point set.
`timescale 1ns / 100ps
module tb_top;
   import mer_pkg::*;
   import ellipse_tracker_pkg::*;

   localparam int ITEM_TARGET = 1500;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 200;

   logic    clock, reset;
   logic    req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;

   ellipse_tracker tracker;
   int items_done = 0;
   int gap_pct = 20;
   bit quiet = 1'b0;
   bit long_hold_req = 1'b0;

   midpoint_ellipse_rasterizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type make_start(logic [COORD_BITS-1:0] x0, y0, rx, ry);
      req_type item;
      item.mode = MODE_START;
      item.x_center = x0;
      item.y_center = y0;
      item.radius_x = rx;
      item.radius_y = ry;
      return item;
   endfunction

   function automatic req_type make_step();
      req_type item;
      item = req_type'($urandom);
      item.mode = MODE_STEP;
      return item;
   endfunction

   task automatic send_command(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (tracker.note_command(item)) items_done++;
      if (!quiet && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic draw_ellipse(input logic [COORD_BITS-1:0] x0, y0, rx, ry,
                               input int max_steps);
      int n;
      send_command(make_start(x0, y0, rx, ry));
      n = 0;
      while (tracker.is_drawing() && n < max_steps) begin
         send_command(make_step());
         n++;
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int choice, span;
      bit held, drained;
      held = 1'b0;
      drained = 1'b0;
      tracker = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      draw_ellipse(10'd0, 10'd0, 10'd0, 10'd0, 0);
      send_command(make_step());
      draw_ellipse(10'd1023, 10'd1023, 10'd1023, 10'd1023, 2);
      draw_ellipse(10'd0, 10'd0, 10'd1023, 10'd1023, 1);
      draw_ellipse(10'd512, 10'd300, 10'd0, 10'd4, 100);
      draw_ellipse(10'd1023, 10'd0, 10'd6, 10'd0, 100);
      send_command(make_step());
      draw_ellipse(10'd5, 10'd5, 10'd3, 10'd2, 100);
      draw_ellipse(10'd0, 10'd1023, 10'd1, 10'd1023, 3);
      draw_ellipse(10'd1023, 10'd0, 10'd1023, 10'd1, 4);

      while (items_done < ITEM_TARGET) begin
         if (!held && items_done > 300) begin
            held = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!drained && items_done > 700) begin
            drained = 1'b1;
            wait_for_drain();
         end
         quiet = (items_done > ITEM_TARGET - 200);
         case ($urandom_range(2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 35;
         endcase
         choice = $urandom_range(99);
         if (choice < 75) begin
            span = ($urandom_range(3) == 0) ? 40 : 10;
            draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom_range(0, span)),
                         COORD_BITS'($urandom_range(0, span)),
                         ($urandom_range(9) == 0) ? $urandom_range(0, 8) : 1 << 20);
         end else if (choice < 88) begin
            draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom),
                         $urandom_range(1, 30));
         end else begin
            repeat ($urandom_range(1, 3)) send_command(make_step());
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("[midpoint_ellipse_rasterizer] OK");
      else
         $display("[midpoint_ellipse_rasterizer] ERROR");
      $finish;
   end

   // result side: random stall bursts plus one long hold-off
   initial begin
      int stall_left, hold_left, rate, cycles;
      stall_left = 0;
      hold_left = 0;
      rate = 10;
      cycles = 0;
      rsp_ready <= 1'b0;
      repeat (2) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) tracker.check_point_set(rsp_data);
         cycles++;
         if (cycles % 300 == 0) begin
            case ($urandom_range(2))
               0: rate = 0;
               1: rate = 8;
               default: rate = 30;
            endcase
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) hold_left--;
         else if (stall_left > 0) stall_left--;
         else if (!quiet && $urandom_range(99) < rate) stall_left = $urandom_range(1, 9);
         rsp_ready <= (hold_left == 0 && stall_left == 0);
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      int stuck;
      stuck = 0;
      repeat (2) @(posedge clock);
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck = 0;
         else stuck++;
         if (stuck >= STALL_LIMIT) begin
            $display("[midpoint_ellipse_rasterizer] ERROR");
            $finish;
         end
      end
   end

endmodule
